// ===== rtl/sha1_stream_hasher_defines.svh =====
// Assertion helpers used by the stream hasher RTL.
`ifndef SHA1_STREAM_HASHER_DEFINES_SVH
`define SHA1_STREAM_HASHER_DEFINES_SVH

// Same-cycle implication, checked on clk, idle while arst_n is low.
`define SHA1_ASSERT_NOW(lbl, ante, cons, text) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(text);

// Next-cycle implication, checked on clk, idle while arst_n is low.
`define SHA1_ASSERT_NEXT(lbl, ante, cons, text) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(text);

`endif

// ===== rtl/sha1_pkg.sv =====
package sha1_pkg;

	localparam int unsigned WORD_W    = 32;
	localparam int unsigned BLK_WORDS = 16;
	localparam int unsigned CHAIN_N   = 5;
	localparam int unsigned FILL_W    = 6;
	localparam int unsigned LEN_W     = 64;
	localparam int unsigned RND_W     = 7;
	localparam int unsigned IDX_W     = 3;

	typedef logic [BLK_WORDS-1:0][WORD_W-1:0] sha1_block_t;
	typedef logic [CHAIN_N-1:0][WORD_W-1:0]   sha1_chain_t;

	localparam sha1_chain_t H_INIT = {
		32'hc3d2e1f0, 32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
	};
	localparam logic [3:0][WORD_W-1:0] ROUND_K = {
		32'hca62c1d6, 32'h8f1bbcdc, 32'h6ed9eba1, 32'h5a827999
	};

	localparam logic [RND_W-1:0]  LAST_ROUND = RND_W'(79);
	localparam logic [FILL_W-1:0] FILL_LAST  = FILL_W'(63);
	localparam logic [FILL_W-1:0] PAD_LIMIT  = FILL_W'(56);
	localparam logic [IDX_W-1:0]  LAST_IDX   = IDX_W'(CHAIN_N - 1);
	localparam logic [7:0]        PAD_BYTE   = 8'h80;

	typedef enum logic [1:0] {
		PH_CH,
		PH_PAR1,
		PH_MAJ,
		PH_PAR2
	} sha1_phase_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_COMP,
		ST_PAD,
		ST_LEN,
		ST_OUT
	} sha1_state_t;

	typedef struct packed {
		logic start;
		logic init;
	} sha1_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} sha1_sts_t;

	function automatic logic [WORD_W-1:0] sha1_f(
		input sha1_phase_t ph,
		input logic [WORD_W-1:0] b,
		input logic [WORD_W-1:0] c,
		input logic [WORD_W-1:0] d
	);
		logic [WORD_W-1:0] r;
		case (ph)
			PH_CH:   r = (b & c) | (~b & d);
			PH_MAJ:  r = (b & c) | (b & d) | (c & d);
			default: r = b ^ c ^ d;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/sha1_if.sv =====
interface sha1_msg_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       byte_present;
	logic       end_of_message;

	modport source (output valid, output data_byte, output byte_present,
		output end_of_message, input ready);
	modport sink (input valid, input data_byte, input byte_present,
		input end_of_message, output ready);
endinterface

interface sha1_dig_if;
	logic                           valid;
	logic                           ready;
	logic [sha1_pkg::WORD_W-1:0]    digest_word;
	logic [sha1_pkg::IDX_W-1:0]     word_index;
	logic                           last_word;

	modport source (output valid, output digest_word, output word_index,
		output last_word, input ready);
	modport sink (input valid, input digest_word, input word_index,
		input last_word, output ready);
endinterface

// ===== rtl/sha1_core.sv =====
module sha1_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sha1_pkg::sha1_ctl_t   ctl,
	input  sha1_pkg::sha1_block_t blk,
	output sha1_pkg::sha1_sts_t   sts,
	output sha1_pkg::sha1_chain_t chain
);

	sha1_pkg::sha1_chain_t              h_q;
	sha1_pkg::sha1_block_t              win_q;
	logic [sha1_pkg::WORD_W-1:0]        a_q, b_q, c_q, d_q, e_q;
	logic [sha1_pkg::RND_W-1:0]         rnd_q;
	logic                               run_q;
	logic                               upd_q;
	sha1_pkg::sha1_phase_t              ph;
	logic [sha1_pkg::WORD_W-1:0]        t_sum;
	logic [sha1_pkg::WORD_W-1:0]        w_mix;
	logic [sha1_pkg::WORD_W-1:0]        w_new;

	always_comb begin
		if (rnd_q inside {[7'd0:7'd19]}) begin
			ph = sha1_pkg::PH_CH;
		end else if (rnd_q inside {[7'd20:7'd39]}) begin
			ph = sha1_pkg::PH_PAR1;
		end else if (rnd_q inside {[7'd40:7'd59]}) begin
			ph = sha1_pkg::PH_MAJ;
		end else begin
			ph = sha1_pkg::PH_PAR2;
		end
	end

	// One round: the shared adder chain for this block
	assign t_sum = {a_q[26:0], a_q[31:27]} + sha1_pkg::sha1_f(ph, b_q, c_q, d_q)
		+ e_q + win_q[0] + sha1_pkg::ROUND_K[ph];

	// Window holds w[t..t+15]; shift in w[t+16]
	assign w_mix = win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0];
	assign w_new = {w_mix[30:0], w_mix[31]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q   <= sha1_pkg::H_INIT;
			run_q <= 1'b0;
			upd_q <= 1'b0;
			rnd_q <= '0;
		end else begin
			upd_q <= run_q && (rnd_q == sha1_pkg::LAST_ROUND);
			if (ctl.start) begin
				run_q <= 1'b1;
				rnd_q <= '0;
			end else if (run_q) begin
				rnd_q <= rnd_q + 1'b1;
				if (rnd_q == sha1_pkg::LAST_ROUND) begin
					run_q <= 1'b0;
				end
			end
			if (upd_q) begin
				h_q[0] <= h_q[0] + a_q;
				h_q[1] <= h_q[1] + b_q;
				h_q[2] <= h_q[2] + c_q;
				h_q[3] <= h_q[3] + d_q;
				h_q[4] <= h_q[4] + e_q;
			end
			if (ctl.init) begin
				h_q <= sha1_pkg::H_INIT;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			a_q   <= h_q[0];
			b_q   <= h_q[1];
			c_q   <= h_q[2];
			d_q   <= h_q[3];
			e_q   <= h_q[4];
			win_q <= blk;
		end else if (run_q) begin
			a_q <= t_sum;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
			for (int i = 0; i < sha1_pkg::BLK_WORDS - 1; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[sha1_pkg::BLK_WORDS-1] <= w_new;
		end
	end

	assign sts.busy = run_q | upd_q;
	assign sts.done = upd_q;
	assign chain    = h_q;

endmodule

// ===== rtl/sha1_stream_hasher.sv =====
// A byte is stored as it is taken; a byte that fills a block also starts its compression.
// End of message: a padding step, an extra compression if 56 or more bytes were
// pending, a length step and its compression, then five words on digest.
// Blocks go through the single round unit one at a time: 80 rounds plus load and update; no byte is taken meanwhile.
// Reset (arst_n low, asynchronous): empty block, zero length, initial chain.
`include "sha1_stream_hasher_defines.svh"

module sha1_stream_hasher (
	input logic        clk,
	input logic        arst_n,
	sha1_msg_if.sink   msg,
	sha1_dig_if.source digest
);

	sha1_pkg::sha1_state_t           state_q, state_d;
	sha1_pkg::sha1_state_t           ret_q, ret_d;
	sha1_pkg::sha1_block_t           blk_q;
	sha1_pkg::sha1_chain_t           chain;
	sha1_pkg::sha1_ctl_t             ctl;
	sha1_pkg::sha1_sts_t             sts;
	logic [sha1_pkg::FILL_W-1:0]     fill_q;
	logic [sha1_pkg::LEN_W-1:0]      bits_q;
	logic [sha1_pkg::IDX_W-1:0]      idx_q;
	logic                            msg_xfer;
	logic                            out_xfer;
	logic                            out_last;
	logic [4:0]                      lane_lsb;

	sha1_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.blk    (blk_q),
		.sts    (sts),
		.chain  (chain)
	);

	assign msg_xfer = msg.valid && msg.ready;
	assign out_xfer = digest.valid && digest.ready;
	assign out_last = idx_q == sha1_pkg::LAST_IDX;
	assign lane_lsb = {~fill_q[1:0], 3'b000};

	always_comb begin
		state_d = state_q;
		ret_d   = ret_q;
		case (state_q)
			sha1_pkg::ST_IDLE: begin
				if (msg.valid) begin
					if (msg.byte_present && fill_q == sha1_pkg::FILL_LAST) begin
						state_d = sha1_pkg::ST_COMP;
						ret_d   = msg.end_of_message ? sha1_pkg::ST_PAD : sha1_pkg::ST_IDLE;
					end else if (msg.end_of_message) begin
						state_d = sha1_pkg::ST_PAD;
					end
				end
			end
			sha1_pkg::ST_COMP: begin
				if (sts.done) begin
					state_d = ret_q;
				end
			end
			sha1_pkg::ST_PAD: begin
				// no room left for the length: spill into an extra block
				if (fill_q >= sha1_pkg::PAD_LIMIT) begin
					state_d = sha1_pkg::ST_COMP;
					ret_d   = sha1_pkg::ST_LEN;
				end else begin
					state_d = sha1_pkg::ST_LEN;
				end
			end
			sha1_pkg::ST_LEN: begin
				state_d = sha1_pkg::ST_COMP;
				ret_d   = sha1_pkg::ST_OUT;
			end
			sha1_pkg::ST_OUT: begin
				if (digest.ready && out_last) begin
					state_d = sha1_pkg::ST_IDLE;
				end
			end
			default: state_d = sha1_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		msg.ready          = state_q == sha1_pkg::ST_IDLE;
		digest.valid       = state_q == sha1_pkg::ST_OUT;
		digest.digest_word = chain[idx_q];
		digest.word_index  = idx_q;
		digest.last_word   = out_last;
		// kick the core on the first cycle after the block is settled
		ctl.start          = (state_q == sha1_pkg::ST_COMP) && !sts.busy;
		ctl.init           = out_xfer && out_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sha1_pkg::ST_IDLE;
			ret_q   <= sha1_pkg::ST_IDLE;
			fill_q  <= '0;
			bits_q  <= '0;
			idx_q   <= '0;
			blk_q   <= '0;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
			if (msg_xfer && msg.byte_present) begin
				blk_q[fill_q[5:2]][lane_lsb +: 8] <= msg.data_byte;
				fill_q <= fill_q + 1'b1;
				bits_q <= bits_q + sha1_pkg::LEN_W'(8);
			end
			if (state_q == sha1_pkg::ST_PAD) begin
				blk_q[fill_q[5:2]][lane_lsb +: 8] <= sha1_pkg::PAD_BYTE;
				fill_q <= fill_q + 1'b1;
			end
			if (state_q == sha1_pkg::ST_LEN) begin
				blk_q[14] <= bits_q[63:32];
				blk_q[15] <= bits_q[31:0];
			end
			if (sts.done) begin
				blk_q  <= '0;
				fill_q <= '0;
			end
			if (out_xfer) begin
				idx_q <= out_last ? '0 : idx_q + 1'b1;
				if (out_last) begin
					bits_q <= '0;
				end
			end
		end
	end

	`SHA1_ASSERT_NOW(a_done_in_comp, sts.done, state_q == sha1_pkg::ST_COMP, "core finished outside compression")
	`SHA1_ASSERT_NEXT(a_start_taken, (state_q == sha1_pkg::ST_COMP) && !sts.busy, sts.busy, "core did not take start")
	`SHA1_ASSERT_NEXT(a_len_to_comp, state_q == sha1_pkg::ST_LEN, state_q == sha1_pkg::ST_COMP, "length block not compressed")
	`SHA1_ASSERT_NEXT(a_clean_restart, out_xfer && digest.last_word, (state_q == sha1_pkg::ST_IDLE) && (fill_q == '0) && (bits_q == '0), "state not cleared after digest")

endmodule
